// ===== design/nle_pkg.sv =====
// ----------------------------------------------------------------------------
// nle_pkg
// Shared types and codes for the number-to-LCD expander stream.
// ----------------------------------------------------------------------------
package nle_pkg;

  localparam int CHAR_SLOTS = 10;

  typedef enum logic [2:0] {
    CMD_RAW_COMMAND = 3'd0,
    CMD_RAW_CHAR    = 3'd1,
    CMD_DECIMAL     = 3'd2,
    CMD_HEX         = 3'd3,
    CMD_BINARY      = 3'd4
  } nle_cmd_t;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_BACKLIGHT_ON   = 2'd1;

  localparam logic [6:0] RESET_DEVICE_ADDRESS = 7'd39;
  localparam logic       RESET_BACKLIGHT_ON   = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] value;
    logic [2:0]  digit_count;
    logic [2:0]  point_position;
  } nle_in_t;

  typedef struct packed {
    logic [6:0] target_address;
    logic [7:0] expander_byte;
    logic       last_of_run;
  } nle_out_t;

  // Request in flight through the BCD conversion stages
  typedef struct packed {
    nle_in_t     req;
    logic [19:0] bcd;
    logic [15:0] bin;
  } nle_dd_t;

  // Character run handed to the serialiser
  typedef struct packed {
    logic [CHAR_SLOTS-1:0][7:0] chars;
    logic                       sel;
    logic [3:0]                 count;
  } nle_run_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic       backlight_on;
  } nle_cfg_t;

endpackage

// ===== design/number_to_lcd_expander_stream.sv =====
// ----------------------------------------------------------------------------
// number_to_lcd_expander_stream
// Formats display requests into port-expander bytes for a 4-bit text display.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per beat (raw command, raw character, decimal, hex,
//           binary). Requests with a bad digit count or point, or an unknown
//           command, give no output.
//   out_* : one expander byte per beat, four per character, last_of_run set
//           on the final byte of a request.
//   cfg_* : register writes (device address, backlight), always ready; write
//           only while the block is idle.
// Path: the first byte of a request passes the two conversion stages,
//   formatting, the serialiser and the output register on its way to out_*.
// Throughput: a request gives four bytes per character it produces, 4 to 40;
//   the serialiser's one-byte-per-cycle output, unless out_ready is low, sets
//   it. Requests enter back to back, queuing in the pipeline stages meanwhile.
// Reset: pipeline empties, registers return to address 39, backlight on.
// Stall: when out_ready is low the output beat holds and the stages fill up,
//   then in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module number_to_lcd_expander_stream (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nle_pkg::nle_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nle_pkg::nle_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data
);
  import nle_pkg::*;

  nle_cfg_t cfg_r, cfg_nxt;
  logic     dd_valid, dd_ready;
  nle_dd_t  dd_data;
  logic     run_valid, run_ready;
  nle_run_t run_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: cfg_nxt.device_address = cfg_data;
        CFG_BACKLIGHT_ON:   cfg_nxt.backlight_on   = cfg_data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= RESET_DEVICE_ADDRESS;
      cfg_r.backlight_on   <= RESET_BACKLIGHT_ON;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nle_bcd u_bcd (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dd_valid (dd_valid),
    .dd_ready (dd_ready),
    .dd_data  (dd_data)
  );

  nle_fmt u_fmt (
    .clk       (clk),
    .rst_n     (rst_n),
    .dd_valid  (dd_valid),
    .dd_ready  (dd_ready),
    .dd_data   (dd_data),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run_data  (run_data)
  );

  nle_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run_data  (run_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Enable-high beat is always followed at once by its enable-low partner
  a_enable_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.expander_byte[2] |=> out_valid)
    else $error("enable-low beat did not follow");

  a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_run |-> !out_data.expander_byte[2])
    else $error("last beat of a run has enable set");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !run_valid && !dd_valid)
    else $error("pipeline not empty after reset");

  a_cfg_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == CFG_DEVICE_ADDRESS
    |=> cfg_r.device_address == $past(cfg_data))
    else $error("device address write lost");

endmodule

// ===== design/nle_bcd.sv =====
// ----------------------------------------------------------------------------
// nle_bcd
// Two-stage double-dabble conversion of the 16-bit value to five BCD digits.
// ----------------------------------------------------------------------------
module nle_bcd (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  nle_pkg::nle_in_t in_data,
  output logic             dd_valid,
  input  logic             dd_ready,
  output nle_pkg::nle_dd_t dd_data
);
  import nle_pkg::*;

  // Eight shift-and-adjust steps on the {bcd, bin} word
  function automatic logic [35:0] dd_half(input logic [35:0] s);
    logic [35:0] w;
    w = s;
    for (int step = 0; step < 8; step++) begin
      for (int d = 0; d < 5; d++) begin
        if (w[16 + 4*d +: 4] >= 4'd5) begin
          w[16 + 4*d +: 4] = w[16 + 4*d +: 4] + 4'd3;
        end
      end
      w = {w[34:0], 1'b0};
    end
    return w;
  endfunction

  logic    s1_valid_r, s1_valid_nxt;
  nle_dd_t s1_r, s1_nxt;
  logic    s2_valid_r, s2_valid_nxt;
  nle_dd_t s2_r, s2_nxt;
  logic    s1_ready, s2_ready;
  logic    s1_take, s2_take;
  logic [35:0] w1, w2;

  assign s2_ready = !s2_valid_r || dd_ready;
  assign s2_take  = s1_valid_r && s2_ready;
  assign s1_ready = !s1_valid_r || s2_take;
  assign s1_take  = in_valid && s1_ready;
  assign in_ready = s1_ready;

  always_comb begin
    w1 = dd_half({20'd0, in_data.value});
    w2 = dd_half({s1_r.bcd, s1_r.bin});
  end

  always_comb begin
    s1_nxt       = s1_r;
    s1_valid_nxt = s1_valid_r;
    if (s1_take) begin
      s1_nxt.req   = in_data;
      s1_nxt.bcd   = w1[35:16];
      s1_nxt.bin   = w1[15:0];
      s1_valid_nxt = 1'b1;
    end else if (s2_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_nxt       = s2_r;
    s2_valid_nxt = s2_valid_r;
    if (s2_take) begin
      s2_nxt.req   = s1_r.req;
      s2_nxt.bcd   = w2[35:16];
      s2_nxt.bin   = w2[15:0];
      s2_valid_nxt = 1'b1;
    end else if (dd_ready) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
  end

  assign dd_valid = s2_valid_r;
  assign dd_data  = s2_r;

endmodule

// ===== design/nle_fmt.sv =====
// ----------------------------------------------------------------------------
// nle_fmt
// Formatting stage: turns a converted request into its run of characters.
// ----------------------------------------------------------------------------
module nle_fmt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              dd_valid,
  output logic              dd_ready,
  input  nle_pkg::nle_dd_t  dd_data,
  output logic              run_valid,
  input  logic              run_ready,
  output nle_pkg::nle_run_t run_data
);
  import nle_pkg::*;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
  endfunction

  function automatic logic [3:0] dsel(input logic [19:0] bcd, input logic [2:0] k);
    logic [3:0] r;
    case (k)
      3'd0:    r = bcd[3:0];
      3'd1:    r = bcd[7:4];
      3'd2:    r = bcd[11:8];
      3'd3:    r = bcd[15:12];
      3'd4:    r = bcd[19:16];
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  logic     valid_r, valid_nxt;
  nle_run_t run_r, run_nxt;
  nle_run_t built;
  logic     take;
  logic [2:0] cnt, pe, dot;
  logic       dec_ok;
  logic [3:0] dec_n;
  logic [3:0] jj [CHAR_SLOTS];
  logic [3:0] ii [CHAR_SLOTS];
  logic [2:0] kk [CHAR_SLOTS];
  logic [7:0] dec_chars [CHAR_SLOTS];

  assign dd_ready = !valid_r || run_ready;
  assign take     = dd_valid && dd_ready;

  // Decimal layout: digits left to right, point before the fractional part
  always_comb begin
    cnt    = dd_data.req.digit_count;
    pe     = (cnt == 3'd1) ? 3'd0 : dd_data.req.point_position;
    dec_ok = (cnt >= 3'd1) && (cnt <= 3'd5) && ((cnt == 3'd1) || (pe < cnt));
    dot    = cnt - pe;
    dec_n  = {1'b0, cnt} + ((pe != 3'd0) ? 4'd1 : 4'd0);
    for (int j = 0; j < CHAR_SLOTS; j++) begin
      jj[j] = 4'(j);
      ii[j] = ((pe != 3'd0) && (jj[j] > {1'b0, dot})) ? jj[j] - 4'd1 : jj[j];
      kk[j] = 3'({1'b0, cnt} - 4'd1 - ii[j]);
      if ((pe != 3'd0) && (jj[j] == {1'b0, dot})) begin
        dec_chars[j] = 8'h2E;
      end else begin
        dec_chars[j] = 8'h30 + {4'd0, dsel(dd_data.bcd, kk[j])};
      end
    end
  end

  always_comb begin
    built       = '0;
    built.sel   = 1'b1;
    case (dd_data.req.command)
      CMD_RAW_COMMAND: begin
        built.chars[0] = dd_data.req.value[7:0];
        built.sel      = 1'b0;
        built.count    = 4'd1;
      end
      CMD_RAW_CHAR: begin
        built.chars[0] = dd_data.req.value[7:0];
        built.count    = 4'd1;
      end
      CMD_DECIMAL: begin
        for (int j = 0; j < CHAR_SLOTS; j++) begin
          built.chars[j] = dec_chars[j];
        end
        built.count = dec_ok ? dec_n : 4'd0;
      end
      CMD_HEX: begin
        built.chars[0] = 8'h30;
        built.chars[1] = 8'h78;
        built.chars[2] = hex_char(dd_data.req.value[7:4]);
        built.chars[3] = hex_char(dd_data.req.value[3:0]);
        built.count    = 4'd4;
      end
      CMD_BINARY: begin
        built.chars[0] = 8'h30;
        built.chars[1] = 8'h62;
        for (int b = 0; b < 8; b++) begin
          built.chars[2 + b] = dd_data.req.value[7 - b] ? 8'h31 : 8'h30;
        end
        built.count = 4'd10;
      end
      default: built.count = 4'd0;
    endcase
  end

  // Drop requests that produce no characters here
  always_comb begin
    run_nxt   = run_r;
    valid_nxt = valid_r;
    if (take) begin
      run_nxt   = built;
      valid_nxt = (built.count != 4'd0);
    end else if (run_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

  assign run_valid = valid_r;
  assign run_data  = run_r;

endmodule

// ===== design/nle_ser.sv =====
// ----------------------------------------------------------------------------
// nle_ser
// Serialiser: four expander bytes per character, one beat a cycle unless stalled.
// ----------------------------------------------------------------------------
module nle_ser (
  input  logic              clk,
  input  logic              rst_n,
  input  nle_pkg::nle_cfg_t cfg,
  input  logic              run_valid,
  output logic              run_ready,
  input  nle_pkg::nle_run_t run_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nle_pkg::nle_out_t out_data
);
  import nle_pkg::*;

  logic                       busy_r, busy_nxt;
  logic [CHAR_SLOTS-1:0][7:0] chars_r, chars_nxt;
  logic                       sel_r, sel_nxt;
  logic [3:0]                 rem_r, rem_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic                       out_valid_r, out_valid_nxt;
  nle_out_t                   out_r, out_nxt;
  logic                       emit, last, load;
  logic [3:0]                 nib;
  logic [7:0]                 pbyte;

  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign last      = (rem_r == 4'd1) && (phase_r == 2'd3);
  assign run_ready = !busy_r || (emit && last);
  assign load      = run_valid && run_ready;

  always_comb begin
    nib   = phase_r[1] ? chars_r[0][3:0] : chars_r[0][7:4];
    pbyte = {nib, cfg.backlight_on, !phase_r[0], 1'b0, sel_r};
  end

  always_comb begin
    busy_nxt  = busy_r;
    chars_nxt = chars_r;
    sel_nxt   = sel_r;
    rem_nxt   = rem_r;
    phase_nxt = phase_r;
    if (emit) begin
      phase_nxt = phase_r + 2'd1;
      if (phase_r == 2'd3) begin
        // advance to the next character
        chars_nxt = {8'h00, chars_r[CHAR_SLOTS-1:1]};
        rem_nxt   = rem_r - 4'd1;
      end
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt  = 1'b1;
      chars_nxt = run_data.chars;
      sel_nxt   = run_data.sel;
      rem_nxt   = run_data.count;
      phase_nxt = 2'd0;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_nxt.target_address = cfg.device_address;
      out_nxt.expander_byte  = pbyte;
      out_nxt.last_of_run    = last;
      out_valid_nxt          = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 2'd0;
      rem_r       <= 4'd0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
    sel_r   <= sel_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the number-to-LCD expander stream: a directed set
// of requests covering field extremes and the invalid decimal cases, then
// random requests over several register settings. Each accepted request is
// formatted locally into expander beats and compared with the output stream,
// with random gaps on the request side and random back-pressure on output.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nle_pkg::*;

  localparam logic [7:0] BIT_BACKLIGHT    = 8'h08;
  localparam logic [7:0] BIT_ENABLE       = 8'h04;
  localparam logic [7:0] BIT_SELECT       = 8'h01;
  localparam logic [7:0] ASCII_ZERO       = 8'h30;
  localparam logic [7:0] ASCII_HEX_OFFSET = 8'h37;
  localparam logic [7:0] ASCII_ONE        = 8'h31;
  localparam logic [7:0] ASCII_POINT      = 8'h2E;
  localparam logic [7:0] ASCII_X          = 8'h78;
  localparam logic [7:0] ASCII_B          = 8'h62;
  localparam int         MAX_REPORTS      = 10;
  localparam int         SETTLE_CYCLES    = 12;
  localparam int         PHASES           = 5;
  localparam int         PHASE_REQUESTS   = 76;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  nle_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  nle_out_t          out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [6:0]        cfg_data = '0;

  nle_in_t           pending_requests[$];
  nle_out_t          expected_beats[$];
  logic [6:0]        addr_shadow = RESET_DEVICE_ADDRESS;
  logic              backlight_shadow = RESET_BACKLIGHT_ON;
  int                requests_queued = 0;
  int                requests_taken = 0;
  int                mismatches = 0;
  logic              in_taken = 1'b0;
  int                send_gap = 0;
  int                send_calm = 0;
  int                stall_left = 0;
  int                recv_calm = 0;

  number_to_lcd_expander_stream dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? ASCII_ZERO + 8'(nib) : ASCII_HEX_OFFSET + 8'(nib);
  endfunction

  // Characters (or the one command byte) that a request puts on the display
  function automatic int format_request(input nle_in_t req, output logic [9:0][7:0] text);
    int n;
    int cnt;
    int pt;
    int k;
    int div;
    int d;
    int i;
    n = 0;
    text = '0;
    case (req.command)
      CMD_RAW_COMMAND, CMD_RAW_CHAR: begin
        text[0] = req.value[7:0];
        n = 1;
      end
      CMD_DECIMAL: begin
        cnt = int'(req.digit_count);
        pt = int'(req.point_position);
        if (cnt == 1) pt = 0;
        if (cnt >= 1 && cnt <= 5 && pt < cnt) begin
          for (i = 0; i < cnt; i++) begin
            k = cnt - 1 - i;
            div = 1;
            repeat (k) div = div * 10;
            d = (int'(req.value) / div) % 10;
            if (pt != 0 && i == cnt - pt) begin
              text[n] = ASCII_POINT;
              n++;
            end
            text[n] = ASCII_ZERO + 8'(d);
            n++;
          end
        end
      end
      CMD_HEX: begin
        text[0] = ASCII_ZERO;
        text[1] = ASCII_X;
        text[2] = hex_digit(req.value[7:4]);
        text[3] = hex_digit(req.value[3:0]);
        n = 4;
      end
      CMD_BINARY: begin
        text[0] = ASCII_ZERO;
        text[1] = ASCII_B;
        for (i = 0; i < 8; i++) text[2 + i] = req.value[7 - i] ? ASCII_ONE : ASCII_ZERO;
        n = 10;
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  // Expand each character into its four nibble beats
  function automatic void queue_expander_beats(input nle_in_t req);
    logic [9:0][7:0] text;
    logic [7:0]      flags;
    logic [7:0]      hi;
    logic [7:0]      lo;
    nle_out_t        beat;
    int              n;
    int              i;
    int              j;
    n = format_request(req, text);
    flags = (backlight_shadow ? BIT_BACKLIGHT : 8'h00) |
            ((req.command != CMD_RAW_COMMAND) ? BIT_SELECT : 8'h00);
    for (i = 0; i < n; i++) begin
      hi = {text[i][7:4], 4'h0} | flags;
      lo = {text[i][3:0], 4'h0} | flags;
      for (j = 0; j < 4; j++) begin
        beat.target_address = addr_shadow;
        beat.expander_byte = ((j < 2) ? hi : lo) | ((j % 2 == 0) ? BIT_ENABLE : 8'h00);
        beat.last_of_run = (i == n - 1 && j == 3);
        expected_beats.push_back(beat);
      end
    end
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic nle_in_t random_request();
    nle_in_t req;
    int      r;
    int      pick;
    int      cnt;
    req.value = 16'($urandom);
    req.digit_count = 3'($urandom);
    req.point_position = 3'($urandom);
    r = $urandom_range(0, 99);
    if (r < 8) req.value = 16'hFFFF;
    else if (r < 14) req.value = 16'h0000;
    else if (r < 35) req.value = 16'($urandom_range(0, 999));
    pick = $urandom_range(0, 99);
    if (pick < 12) req.command = CMD_RAW_COMMAND;
    else if (pick < 24) req.command = CMD_RAW_CHAR;
    else if (pick < 62) begin
      req.command = CMD_DECIMAL;
      cnt = $urandom_range(1, 5);
      req.digit_count = 3'(cnt);
      if (cnt > 1) req.point_position = 3'($urandom_range(0, cnt - 1));
    end
    else if (pick < 76) req.command = CMD_HEX;
    else if (pick < 90) req.command = CMD_BINARY;
    else if (pick < 95) req.command = CMD_DECIMAL;
    else req.command = 3'($urandom);
    return req;
  endfunction

  task automatic push_request(input logic [2:0] cmd, input logic [15:0] value,
                              input logic [2:0] cnt, input logic [2:0] pt);
    nle_in_t req;
    req.command = cmd;
    req.value = value;
    req.digit_count = cnt;
    req.point_position = pt;
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  // Hold until every request is in and every beat is out, then let it settle
  task automatic wait_idle();
    do @(negedge clk);
    while (!(requests_taken == requests_queued && expected_beats.size() == 0));
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_DEVICE_ADDRESS) addr_shadow = data;
    else if (idx == CFG_BACKLIGHT_ON) backlight_shadow = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
        send_gap = next_gap(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = next_gap(recv_calm);
      out_ready <= 1'b1;
    end
  end

  // Monitor: check output beats, then predict from the accepted request beat
  always @(posedge clk) begin
    nle_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected beat: addr %0d byte %02h last %0b",
                     out_data.target_address, out_data.expander_byte, out_data.last_of_run);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data.target_address !== want.target_address ||
              out_data.expander_byte !== want.expander_byte ||
              out_data.last_of_run !== want.last_of_run) begin
            if (mismatches < MAX_REPORTS)
              $display("beat mismatch: want %0d/%02h/%0b got %0d/%02h/%0b",
                       want.target_address, want.expander_byte, want.last_of_run,
                       out_data.target_address, out_data.expander_byte, out_data.last_of_run);
            mismatches++;
          end
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        queue_expander_beats(in_data);
        requests_taken++;
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  initial begin
    logic [6:0]      addr_plan [PHASES];
    logic            light_plan [PHASES];
    logic [9:0][7:0] scratch;
    nle_in_t         req;
    int              ph;
    int              made;
    int              c;
    addr_plan = '{7'd0, 7'd127, 7'($urandom), 7'($urandom), RESET_DEVICE_ADDRESS};
    light_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed set at the reset register values
    push_request(CMD_RAW_COMMAND, 16'h0000, 3'd0, 3'd0);
    push_request(CMD_RAW_COMMAND, 16'hABFF, 3'd7, 3'd7);
    push_request(CMD_RAW_CHAR, 16'h0041, 3'd0, 3'd0);
    push_request(CMD_RAW_CHAR, 16'hFF80, 3'd5, 3'd2);
    push_request(CMD_DECIMAL, 16'hFFFF, 3'd5, 3'd0);
    push_request(CMD_DECIMAL, 16'hFFFF, 3'd5, 3'd4);
    push_request(CMD_DECIMAL, 16'h0000, 3'd1, 3'd7);
    push_request(CMD_DECIMAL, 16'd12345, 3'd3, 3'd2);
    push_request(CMD_DECIMAL, 16'd40009, 3'd4, 3'd1);
    push_request(CMD_DECIMAL, 16'd7, 3'd2, 3'd1);
    push_request(CMD_DECIMAL, 16'd60000, 3'd5, 3'd1);
    push_request(CMD_DECIMAL, 16'd1234, 3'd0, 3'd0);
    push_request(CMD_DECIMAL, 16'd1234, 3'd6, 3'd0);
    push_request(CMD_DECIMAL, 16'd1234, 3'd7, 3'd7);
    push_request(CMD_DECIMAL, 16'd1234, 3'd3, 3'd3);
    push_request(CMD_DECIMAL, 16'd1234, 3'd2, 3'd5);
    push_request(CMD_HEX, 16'h0000, 3'd0, 3'd0);
    push_request(CMD_HEX, 16'hFFFF, 3'd7, 3'd7);
    push_request(CMD_HEX, 16'h12A5, 3'd3, 3'd1);
    push_request(CMD_BINARY, 16'h0000, 3'd0, 3'd0);
    push_request(CMD_BINARY, 16'hFFFF, 3'd7, 3'd7);
    push_request(CMD_BINARY, 16'hC35A, 3'd2, 3'd4);
    for (c = CMD_BINARY + 1; c < 8; c++) push_request(3'(c), 16'h5A5A, 3'd3, 3'd1);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_DEVICE_ADDRESS, addr_plan[ph]);
      write_reg(CFG_BACKLIGHT_ON, {6'($urandom), light_plan[ph]});
      made = 0;
      // requests that produce nothing do not advance the count
      while (made < PHASE_REQUESTS) begin
        req = random_request();
        pending_requests.push_back(req);
        requests_queued++;
        if (format_request(req, scratch) != 0) made++;
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
